// ===== rtl/gpsp_pkg.sv =====
// Package with shared constants, codes and the sequencer state type of the pose slot pool.
package gpsp_pkg;

    localparam int unsigned DEF_MAX_SLOTS        = 256;
    localparam int unsigned DEF_STORAGE_MATRICES = 65536;
    localparam int unsigned DEF_MAX_BONES        = 256;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NO_SPACE  = 2'd3;

    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_REMOVE  = 3'd1;
    localparam logic [2:0] MODE_PUBLISH = 3'd2;
    localparam logic [2:0] MODE_QUERY   = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_SLOT,
        S_SLOT_WAIT,
        S_GEN_WAIT,
        S_WRITE,
        S_LOOK,
        S_DIRTY,
        S_DONE
    } state_t;

endpackage

// ===== rtl/generational_pose_slot_pool.sv =====
// Pose slot pool: one transaction at a time, processed by a small sequencer and memories.
// An add that is rejected early goes from decode straight to done; else it scans the free
// ranges, then claims a slot and writes it. out_valid rises in the same cycle as the sequencer
// returns to idle and can take the next input; a stalled output holds the sequencer in done.
// The free range scan reads one entry per cycle from the range memory and sets throughput.
// Reset clears the counters, storage top, dirty range and sequencer; memories are not cleared.
module generational_pose_slot_pool
    import gpsp_pkg::*;
#(
    parameter int unsigned MAX_SLOTS        = DEF_MAX_SLOTS,
    parameter int unsigned STORAGE_MATRICES = DEF_STORAGE_MATRICES,
    parameter int unsigned MAX_BONES        = DEF_MAX_BONES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [8:0]  new_bones,
    input  logic [7:0]  handle_index,
    input  logic [15:0] handle_generation,
    input  logic [8:0]  matrix_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  new_index,
    output logic [15:0] new_generation,
    output logic [15:0] current_offset,
    output logic [15:0] prior_offset,
    output logic [15:0] start_offset,
    output logic [8:0]  bones,
    output logic        dirty_valid,
    output logic [15:0] dirty_first,
    output logic [15:0] dirty_last
);

    localparam int SI_W   = $clog2(MAX_SLOTS);
    localparam int SC_W   = $clog2(MAX_SLOTS + 1);
    localparam int OFF_W  = $clog2(STORAGE_MATRICES);
    localparam int TOP_W  = OFF_W + 1;
    localparam int BONE_W = $clog2(MAX_BONES + 1);
    localparam int NEED_W = BONE_W + 1;

    typedef struct packed {
        logic              live;
        logic              parity;
        logic [15:0]       gen;
        logic [BONE_W-1:0] bones;
        logic [OFF_W-1:0]  off;
    } slot_t;

    typedef struct packed {
        logic [NEED_W-1:0] size;
        logic [OFF_W-1:0]  off;
    } range_t;

    slot_t  slot_mem [MAX_SLOTS];
    range_t rng_mem  [MAX_SLOTS];
    logic [SI_W-1:0] stk_mem [MAX_SLOTS];

    slot_t           slot_rd_reg;
    range_t          rng_rd_reg;
    logic [SI_W-1:0] stk_rd_reg;

    logic            slot_re, slot_we, rng_re, rng_we, stk_re, stk_we;
    logic [SI_W-1:0] slot_ra, slot_wa, rng_ra, rng_wa, stk_ra, stk_wa;
    slot_t           slot_wd;
    range_t          rng_wd;
    logic [SI_W-1:0] stk_wd;

    state_t state_reg, state_next;

    logic [SC_W-1:0]   sc_reg, sc_next, fsc_reg, fsc_next, frc_reg, frc_next;
    logic [SC_W-1:0]   scan_reg, scan_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic              dv_reg, dv_next;
    logic [OFF_W-1:0]  df_reg, df_next, dl_reg, dl_next;

    logic [2:0]        mode_reg, mode_next;
    logic [8:0]        bin_reg, bin_next, mc_reg, mc_next;
    logic [7:0]        hidx_reg, hidx_next;
    logic [15:0]       hgen_reg, hgen_next;
    logic              chk_reg, chk_next;
    logic [SI_W-1:0]   chk_idx_reg, chk_idx_next, found_reg, found_next;
    logic [SI_W-1:0]   sidx_reg, sidx_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [BONE_W-1:0] sb_reg, sb_next;
    logic              par_reg, par_next;
    logic [15:0]       gen_reg, gen_next;
    logic [1:0]        st_reg, st_next;
    logic              rep_reg, rep_next, newh_reg, newh_next;

    logic              ov_reg, ov_next;
    logic [1:0]        o_status_reg, o_status_next;
    logic [7:0]        o_idx_reg, o_idx_next;
    logic [15:0]       o_gen_reg, o_gen_next;
    logic [15:0]       o_cur_reg, o_cur_next, o_prev_reg, o_prev_next, o_base_reg, o_base_next;
    logic [8:0]        o_bones_reg, o_bones_next;
    logic              o_dv_reg, o_dv_next;
    logic [15:0]       o_df_reg, o_df_next, o_dl_reg, o_dl_next;

    logic [NEED_W-1:0] need;
    logic [OFF_W-1:0]  bones_ext, dfirst, dlast, cur_off, prev_off;
    logic              accept, out_free, add_bad, found_match, scan_more, handle_ok;

    assign accept      = in_valid && (state_reg == S_IDLE);
    assign out_free    = !ov_reg || !out_stall;
    assign need        = NEED_W'(BONE_W'(bin_reg)) << 1;
    assign bones_ext   = OFF_W'(sb_reg);
    assign dfirst      = off_reg + (par_reg ? bones_ext : '0);
    assign dlast       = dfirst + bones_ext - OFF_W'(1);
    assign cur_off     = off_reg + (par_reg ? bones_ext : '0);
    assign prev_off    = off_reg + (par_reg ? '0 : bones_ext);
    assign add_bad     = (bin_reg == 9'd0) || (32'(bin_reg) > 32'(MAX_BONES));
    assign found_match = chk_reg && (rng_rd_reg.size == need);
    assign scan_more   = 32'(scan_reg) < 32'(frc_reg);
    assign handle_ok   = slot_rd_reg.live && (slot_rd_reg.gen == hgen_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (mode_reg == MODE_ADD)
                begin
                    if (add_bad || (fsc_reg == '0 && 32'(sc_reg) >= 32'(MAX_SLOTS)))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (mode_reg == MODE_REMOVE || mode_reg == MODE_PUBLISH ||
                         mode_reg == MODE_QUERY)
                begin
                    if (32'(hidx_reg) >= 32'(sc_reg))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOOK;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                priority if (found_match)
                begin
                    state_next = S_MOVE_RD;
                end
                else if (scan_more || chk_reg)
                begin
                    state_next = S_SCAN;
                end
                else if (32'(top_reg) + 32'(need) > 32'(STORAGE_MATRICES))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SLOT;
                end
            end
            S_MOVE_RD:   state_next = S_MOVE_WR;
            S_MOVE_WR:   state_next = S_SLOT;
            S_SLOT:      state_next = (fsc_reg != '0) ? S_SLOT_WAIT : S_WRITE;
            S_SLOT_WAIT: state_next = S_GEN_WAIT;
            S_GEN_WAIT:  state_next = S_WRITE;
            S_WRITE:     state_next = S_DONE;
            S_LOOK:
            begin
                if (handle_ok && mode_reg == MODE_PUBLISH &&
                    32'(mc_reg) >= 32'(slot_rd_reg.bones))
                begin
                    state_next = S_DIRTY;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIRTY:     state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        sc_next = sc_reg;  fsc_next = fsc_reg;  frc_next = frc_reg;
        scan_next = scan_reg;  top_next = top_reg;
        dv_next = dv_reg;  df_next = df_reg;  dl_next = dl_reg;
        mode_next = mode_reg;  bin_next = bin_reg;  mc_next = mc_reg;
        hidx_next = hidx_reg;  hgen_next = hgen_reg;
        chk_next = 1'b0;  chk_idx_next = chk_idx_reg;  found_next = found_reg;
        sidx_next = sidx_reg;  off_next = off_reg;  sb_next = sb_reg;
        par_next = par_reg;  gen_next = gen_reg;
        st_next = st_reg;  rep_next = rep_reg;  newh_next = newh_reg;
        ov_next = ov_reg && out_stall;
        o_status_next = o_status_reg;  o_idx_next = o_idx_reg;  o_gen_next = o_gen_reg;
        o_cur_next = o_cur_reg;  o_prev_next = o_prev_reg;  o_base_next = o_base_reg;
        o_bones_next = o_bones_reg;  o_dv_next = o_dv_reg;
        o_df_next = o_df_reg;  o_dl_next = o_dl_reg;
        slot_re = 1'b0;  slot_we = 1'b0;  slot_ra = SI_W'(hidx_reg);  slot_wa = sidx_reg;
        slot_wd = '0;
        rng_re = 1'b0;  rng_we = 1'b0;  rng_ra = '0;  rng_wa = '0;  rng_wd = '0;
        stk_re = 1'b0;  stk_we = 1'b0;  stk_ra = '0;  stk_wa = '0;  stk_wd = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode;  bin_next = new_bones;  mc_next = matrix_count;
                    hidx_next = handle_index;  hgen_next = handle_generation;
                    st_next = ST_OK;  rep_next = 1'b0;  newh_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                priority if (mode_reg == MODE_ADD)
                begin
                    scan_next = '0;
                    if (add_bad)
                    begin
                        st_next = ST_INVALID;
                    end
                    else if (fsc_reg == '0 && 32'(sc_reg) >= 32'(MAX_SLOTS))
                    begin
                        st_next = ST_NO_SPACE;
                    end
                end
                else if (mode_reg == MODE_REMOVE || mode_reg == MODE_PUBLISH ||
                         mode_reg == MODE_QUERY)
                begin
                    if (32'(hidx_reg) >= 32'(sc_reg))
                    begin
                        st_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        slot_re = 1'b1;
                    end
                end
                else if (mode_reg == MODE_CLEAR)
                begin
                    dv_next = 1'b0;  df_next = '0;  dl_next = '0;
                end
                else
                begin
                    st_next = ST_INVALID;
                end
            end
            S_SCAN:
            begin
                priority if (found_match)
                begin
                    off_next = rng_rd_reg.off;
                    found_next = chk_idx_reg;
                end
                else if (scan_more)
                begin
                    rng_re = 1'b1;
                    rng_ra = scan_reg[SI_W-1:0];
                    chk_next = 1'b1;
                    chk_idx_next = scan_reg[SI_W-1:0];
                    scan_next = scan_reg + SC_W'(1);
                end
                else if (chk_reg)
                begin
                    chk_next = 1'b0;
                end
                else if (32'(top_reg) + 32'(need) > 32'(STORAGE_MATRICES))
                begin
                    st_next = ST_NO_SPACE;
                end
                else
                begin
                    off_next = top_reg[OFF_W-1:0];
                    top_next = top_reg + TOP_W'(need);
                end
            end
            S_MOVE_RD:
            begin
                rng_re = 1'b1;
                rng_ra = SI_W'(frc_reg - SC_W'(1));
            end
            S_MOVE_WR:
            begin
                rng_we = 1'b1;
                rng_wa = found_reg;
                rng_wd = rng_rd_reg;
                frc_next = frc_reg - SC_W'(1);
            end
            S_SLOT:
            begin
                if (fsc_reg != '0)
                begin
                    fsc_next = fsc_reg - SC_W'(1);
                    stk_re = 1'b1;
                    stk_ra = SI_W'(fsc_reg - SC_W'(1));
                end
                else
                begin
                    sidx_next = SI_W'(sc_reg);
                    gen_next = '0;
                    sc_next = sc_reg + SC_W'(1);
                end
            end
            S_SLOT_WAIT:
            begin
                sidx_next = stk_rd_reg;
                slot_re = 1'b1;
                slot_ra = stk_rd_reg;
            end
            S_GEN_WAIT:
            begin
                gen_next = slot_rd_reg.gen;
            end
            S_WRITE:
            begin
                slot_we = 1'b1;
                slot_wa = sidx_reg;
                slot_wd = '{live: 1'b1, parity: 1'b0, gen: gen_reg,
                            bones: BONE_W'(bin_reg), off: off_reg};
                sb_next = BONE_W'(bin_reg);
                par_next = 1'b0;
                rep_next = 1'b1;
                newh_next = 1'b1;
            end
            S_LOOK:
            begin
                off_next = slot_rd_reg.off;
                sb_next = slot_rd_reg.bones;
                par_next = slot_rd_reg.parity;
                sidx_next = SI_W'(hidx_reg);
                if (!handle_ok)
                begin
                    st_next = ST_NOT_FOUND;
                end
                else
                begin
                    priority if (mode_reg == MODE_REMOVE)
                    begin
                        slot_we = 1'b1;
                        slot_wa = SI_W'(hidx_reg);
                        slot_wd = slot_rd_reg;
                        slot_wd.live = 1'b0;
                        slot_wd.gen = slot_rd_reg.gen + 16'd1;
                        if (32'(frc_reg) < 32'(MAX_SLOTS))
                        begin
                            rng_we = 1'b1;
                            rng_wa = SI_W'(frc_reg);
                            rng_wd.off = slot_rd_reg.off;
                            rng_wd.size = NEED_W'(slot_rd_reg.bones) << 1;
                            frc_next = frc_reg + SC_W'(1);
                        end
                        if (32'(fsc_reg) < 32'(MAX_SLOTS))
                        begin
                            stk_we = 1'b1;
                            stk_wa = SI_W'(fsc_reg);
                            stk_wd = SI_W'(hidx_reg);
                            fsc_next = fsc_reg + SC_W'(1);
                        end
                    end
                    else if (mode_reg == MODE_PUBLISH)
                    begin
                        if (32'(mc_reg) < 32'(slot_rd_reg.bones))
                        begin
                            st_next = ST_INVALID;
                        end
                        else
                        begin
                            par_next = !slot_rd_reg.parity;
                            slot_we = 1'b1;
                            slot_wa = SI_W'(hidx_reg);
                            slot_wd = slot_rd_reg;
                            slot_wd.parity = !slot_rd_reg.parity;
                        end
                    end
                    else
                    begin
                        rep_next = 1'b1;
                    end
                end
            end
            S_DIRTY:
            begin
                if (!dv_reg || dfirst < df_reg)
                begin
                    df_next = dfirst;
                end
                dv_next = 1'b1;
                if (dlast > dl_reg)
                begin
                    dl_next = dlast;
                end
                rep_next = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    o_status_next = st_reg;
                    o_idx_next = newh_reg ? 8'(sidx_reg) : 8'd0;
                    o_gen_next = newh_reg ? gen_reg : 16'd0;
                    o_cur_next = rep_reg ? 16'(cur_off) : 16'd0;
                    o_prev_next = rep_reg ? 16'(prev_off) : 16'd0;
                    o_base_next = rep_reg ? 16'(off_reg) : 16'd0;
                    o_bones_next = rep_reg ? 9'(sb_reg) : 9'd0;
                    o_dv_next = dv_reg;
                    o_df_next = 16'(df_reg);
                    o_dl_next = 16'(dl_reg);
                end
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_rd_reg <= slot_mem[slot_ra];
        end
        if (rng_we)
        begin
            rng_mem[rng_wa] <= rng_wd;
        end
        if (rng_re)
        begin
            rng_rd_reg <= rng_mem[rng_ra];
        end
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sc_reg    <= '0;
            fsc_reg   <= '0;
            frc_reg   <= '0;
            top_reg   <= '0;
            dv_reg    <= 1'b0;
            df_reg    <= '0;
            dl_reg    <= '0;
            chk_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sc_reg    <= sc_next;
            fsc_reg   <= fsc_next;
            frc_reg   <= frc_next;
            top_reg   <= top_next;
            dv_reg    <= dv_next;
            df_reg    <= df_next;
            dl_reg    <= dl_next;
            chk_reg   <= chk_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        mode_reg     <= mode_next;
        bin_reg      <= bin_next;
        mc_reg       <= mc_next;
        hidx_reg     <= hidx_next;
        hgen_reg     <= hgen_next;
        chk_idx_reg  <= chk_idx_next;
        found_reg    <= found_next;
        sidx_reg     <= sidx_next;
        off_reg      <= off_next;
        sb_reg       <= sb_next;
        par_reg      <= par_next;
        gen_reg      <= gen_next;
        st_reg       <= st_next;
        rep_reg      <= rep_next;
        newh_reg     <= newh_next;
        o_status_reg <= o_status_next;
        o_idx_reg    <= o_idx_next;
        o_gen_reg    <= o_gen_next;
        o_cur_reg    <= o_cur_next;
        o_prev_reg   <= o_prev_next;
        o_base_reg   <= o_base_next;
        o_bones_reg  <= o_bones_next;
        o_dv_reg     <= o_dv_next;
        o_df_reg     <= o_df_next;
        o_dl_reg     <= o_dl_next;
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = ov_reg;
    assign status          = o_status_reg;
    assign new_index       = o_idx_reg;
    assign new_generation  = o_gen_reg;
    assign current_offset  = o_cur_reg;
    assign prior_offset    = o_prev_reg;
    assign start_offset    = o_base_reg;
    assign bones           = o_bones_reg;
    assign dirty_valid     = o_dv_reg;
    assign dirty_first     = o_df_reg;
    assign dirty_last      = o_dl_reg;

`ifndef SYNTH
    a_free_slots_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fsc_reg <= sc_reg && 32'(sc_reg) <= 32'(MAX_SLOTS))
        else $error("free slot count exceeds slot count");

    a_ranges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(frc_reg) <= 32'(MAX_SLOTS) && 32'(top_reg) <= 32'(STORAGE_MATRICES))
        else $error("range list or storage top out of bounds");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> scan_reg <= frc_reg)
        else $error("range scan ran past the list");

    a_clean_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        !dv_reg |-> (df_reg == '0 && dl_reg == '0))
        else $error("dirty bounds set without a dirty range");

    a_dirty_order: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> df_reg <= dl_reg)
        else $error("dirty range inverted");
`endif

endmodule
